// File: hdl/mpa_pkg.sv
// Shared types and constants for the multichannel phase alignment block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package mpa_pkg;

    localparam int NCH = 4;
    localparam int SB = 16;
    localparam int STEPS = 28;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_METHOD = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;
    localparam logic signed [15:0] ROT_ONE = 16'sd32767;

    typedef struct packed {
        logic load;
        logic vec_step;
        logic mem_rd;
        logic upd;
        logic full;
        logic div_step;
        logic rot_load;
        logic rot_step;
        logic mul;
        logic live;
        logic method;
        logic hold_inst;
        logic hold_mean;
        logic sum_clr;
    } t_ctrl;

    // Arctangent of 2^-i in 32-bit turns.
    function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/multichannel_phase_align_unit.sv
// Top level: sequencer, window counters, configuration and output register.
// Depends on mpa_pkg, mpa_vec and mpa_lane.
//
// Aligns channels 1 to 3 to the phase of channel 0, which passes through.
// One sample set is processed at a time. With calibration disabled an
// accepted word goes through the multiply into the product registers and
// is rounded into the output register once that is free. With calibration
// enabled the shared step counter runs the arctangent CORDIC, the offset
// history is read and then updated, the rotation CORDIC is loaded and run
// and the multiply follows, in method 0; method 1 adds the bit-serial mean
// divider between the update and the rotation. The next word is taken as
// soon as the previous one is in the output register. The offset history
// needs no clearing after reset.
`default_nettype none
module multichannel_phase_align_unit #(
    parameter int WINDOW_MAX = 1024,
    parameter int PHASE_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [1:0]         i_cfg_index,
    input  wire [10:0]        i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [15:0] i_ch0_re,
    input  wire signed [15:0] i_ch0_im,
    input  wire signed [15:0] i_ch1_re,
    input  wire signed [15:0] i_ch1_im,
    input  wire signed [15:0] i_ch2_re,
    input  wire signed [15:0] i_ch2_im,
    input  wire signed [15:0] i_ch3_re,
    input  wire signed [15:0] i_ch3_im,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [15:0] o_out0_re,
    output logic signed [15:0] o_out0_im,
    output logic signed [15:0] o_out1_re,
    output logic signed [15:0] o_out1_im,
    output logic signed [15:0] o_out2_re,
    output logic signed [15:0] o_out2_im,
    output logic signed [15:0] o_out3_re,
    output logic signed [15:0] o_out3_im
);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int SW = PHASE_BITS + LW;
    localparam int NL = mpa_pkg::NCH - 1;

    typedef enum logic [2:0] {
        S_IDLE, S_VEC, S_RD, S_UPD, S_DIV, S_ROTL, S_ROT, S_MUL
    } t_state;
    localparam t_state S_OUT = t_state'(3'd0);

    t_state r_state;
    logic r_out_wait;
    logic [mpa_pkg::CNT_W-1:0] r_cnt;
    logic r_enable, r_method;
    logic [10:0] r_wlen;
    logic [AW-1:0] r_pos, pos, npos;
    logic [LW-1:0] r_fill, nfill, len;
    logic [31:0] len32;
    logic full, accept, cfg_wr, out_free;
    mpa_pkg::t_ctrl ctrl;
    logic [PHASE_BITS-1:0] ph0;
    logic signed [15:0] r_c0_re, r_c0_im;
    logic signed [15:0] lane_in_re [NL];
    logic signed [15:0] lane_in_im [NL];
    logic signed [15:0] lane_re [NL];
    logic signed [15:0] lane_im [NL];

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid & o_cfg_ready;
    assign o_in_stall = (r_state != S_IDLE) || r_out_wait;
    assign accept = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        if (r_wlen == 11'd0) len32 = 32'd1;
        else if (32'(r_wlen) > WINDOW_MAX) len32 = 32'(WINDOW_MAX);
        else len32 = 32'(r_wlen);
    end
    assign len = len32[LW-1:0];
    assign full = r_fill >= len;
    assign pos = (32'(r_pos) < len32) ? r_pos : '0;
    assign nfill = full ? len : r_fill + 1'b1;
    assign npos = (32'(pos) + 32'd1 >= len32) ? '0 : pos + 1'b1;

    always_comb begin
        ctrl = '0;
        ctrl.load = accept;
        ctrl.vec_step = (r_state == S_VEC);
        ctrl.mem_rd = (r_state == S_RD);
        ctrl.upd = (r_state == S_UPD);
        ctrl.full = full;
        ctrl.div_step = (r_state == S_DIV);
        ctrl.rot_load = (r_state == S_ROTL);
        ctrl.rot_step = (r_state == S_ROT);
        ctrl.mul = (r_state == S_MUL);
        ctrl.live = r_enable;
        ctrl.method = r_method;
        ctrl.hold_inst = r_enable && !r_method && (npos == '0);
        ctrl.hold_mean = r_enable && r_method;
        ctrl.sum_clr = cfg_wr && (i_cfg_index == mpa_pkg::CFG_WINDOW);
    end

    mpa_vec #(.PHASE_BITS(PHASE_BITS)) u_vec0 (
        .i_clk  (i_clk),
        .i_load (ctrl.load),
        .i_step (ctrl.vec_step),
        .i_idx  (r_cnt[mpa_pkg::IDX_W-1:0]),
        .i_x    (i_ch0_re),
        .i_y    (i_ch0_im),
        .o_phase(ph0)
    );

    assign lane_in_re[0] = i_ch1_re;
    assign lane_in_im[0] = i_ch1_im;
    assign lane_in_re[1] = i_ch2_re;
    assign lane_in_im[1] = i_ch2_im;
    assign lane_in_re[2] = i_ch3_re;
    assign lane_in_im[2] = i_ch3_im;

    for (genvar k = 0; k < NL; k++) begin : g_lane
        mpa_lane #(.WINDOW_MAX(WINDOW_MAX), .PHASE_BITS(PHASE_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (ctrl),
            .i_idx  (r_cnt[mpa_pkg::IDX_W-1:0]),
            .i_pos  (pos),
            .i_nfill(nfill),
            .i_ph0  (ph0),
            .i_re   (lane_in_re[k]),
            .i_im   (lane_in_im[k]),
            .o_re   (lane_re[k]),
            .o_im   (lane_im[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c0_re <= i_ch0_re;
            r_c0_im <= i_ch0_im;
        end
    end

    // The finished word waits in the idle state, flagged by r_out_wait,
    // until the output register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_wait <= 1'b0;
            r_cnt <= '0;
            r_enable <= 1'b0;
            r_method <= 1'b0;
            r_wlen <= 11'd256;
            r_pos <= '0;
            r_fill <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !r_out_wait) begin
                o_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (i_cfg_index == mpa_pkg::CFG_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else if (i_cfg_index == mpa_pkg::CFG_METHOD) begin
                    r_method <= i_cfg_data[0];
                end else if (i_cfg_index == mpa_pkg::CFG_WINDOW) begin
                    r_wlen <= i_cfg_data;
                    r_pos <= '0;
                    r_fill <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (r_out_wait) begin
                        if (out_free) begin
                            o_out_valid <= 1'b1;
                            o_out0_re <= r_c0_re;
                            o_out0_im <= r_c0_im;
                            o_out1_re <= lane_re[0];
                            o_out1_im <= lane_im[0];
                            o_out2_re <= lane_re[1];
                            o_out2_im <= lane_im[1];
                            o_out3_re <= lane_re[2];
                            o_out3_im <= lane_im[2];
                            r_out_wait <= 1'b0;
                        end
                    end else if (accept) begin
                        r_cnt <= '0;
                        r_state <= r_enable ? S_VEC : S_MUL;
                    end
                end
                S_VEC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mpa_pkg::CNT_W'(mpa_pkg::STEPS - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_cnt <= '0;
                    r_state <= r_method ? S_DIV : S_ROTL;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mpa_pkg::CNT_W'(SW - 1)) begin
                        r_state <= S_ROTL;
                    end
                end
                S_ROTL: begin
                    r_cnt <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mpa_pkg::CNT_W'(mpa_pkg::STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_enable) begin
                        r_fill <= nfill;
                        r_pos <= npos;
                    end
                    r_out_wait <= 1'b1;
                    r_state <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_fill_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= len) else $error("fill count beyond window length");
    a_pos_lt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < len32) else $error("window position beyond window length");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall) else $error("second word taken while busy");
    a_out_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_out_wait)) else $error("word launched unfinished");
`endif
endmodule
`default_nettype wire

// File: hdl/mpa_vec.sv
// Iterative CORDIC arctangent: one micro-rotation per step, phase in turns.
// Depends on mpa_pkg for the arctangent table and sample width.
`default_nettype none
module mpa_vec #(
    parameter int PHASE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_load,
    input  wire                          i_step,
    input  wire [mpa_pkg::IDX_W-1:0]     i_idx,
    input  wire signed [mpa_pkg::SB-1:0] i_x,
    input  wire signed [mpa_pkg::SB-1:0] i_y,
    output logic [PHASE_BITS-1:0]        o_phase
);
    localparam int XW = mpa_pkg::SB + 3;

    logic signed [XW-1:0] r_x, r_y;
    logic [31:0] r_z;
    logic r_zero;
    logic signed [XW-1:0] xe, ye;
    logic [31:0] zr;

    assign xe = {{3{i_x[mpa_pkg::SB-1]}}, i_x};
    assign ye = {{3{i_y[mpa_pkg::SB-1]}}, i_y};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x[mpa_pkg::SB-1]) begin
                r_x <= -xe;
                r_y <= -ye;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= xe;
                r_y <= ye;
                r_z <= 32'd0;
            end
        end else if (i_step) begin
            if (!r_y[XW-1]) begin
                r_x <= r_x + (r_y >>> i_idx);
                r_y <= r_y - (r_x >>> i_idx);
                r_z <= r_z + mpa_pkg::atan_turn(i_idx);
            end else begin
                r_x <= r_x - (r_y >>> i_idx);
                r_y <= r_y + (r_x >>> i_idx);
                r_z <= r_z - mpa_pkg::atan_turn(i_idx);
            end
        end
    end

    // Round half up to the phase width.
    assign zr = r_z + (32'd1 << (31 - PHASE_BITS));
    assign o_phase = r_zero ? '0 : zr[31 -: PHASE_BITS];
endmodule
`default_nettype wire

// File: hdl/mpa_lane.sv
// One aligned channel: phase, offset window, mean divider, rotation CORDIC
// and complex multiply. Depends on mpa_pkg and mpa_vec.
`default_nettype none
module mpa_lane #(
    parameter int WINDOW_MAX = 1024,
    parameter int PHASE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mpa_pkg::t_ctrl               i_ctrl,
    input  wire [mpa_pkg::IDX_W-1:0]     i_idx,
    input  wire [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] i_pos,
    input  wire [$clog2(WINDOW_MAX + 1)-1:0] i_nfill,
    input  wire [PHASE_BITS-1:0]         i_ph0,
    input  wire signed [mpa_pkg::SB-1:0] i_re,
    input  wire signed [mpa_pkg::SB-1:0] i_im,
    output logic signed [mpa_pkg::SB-1:0] o_re,
    output logic signed [mpa_pkg::SB-1:0] o_im
);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int SW = PHASE_BITS + LW;
    localparam int PW = mpa_pkg::SB + 17;
    localparam logic signed [33:0] QTR = 34'sh0_4000_0000;
    localparam logic signed [33:0] HALF = 34'sh0_8000_0000;
    localparam logic signed [33:0] GAIN = 34'sd652032874;

    logic [PHASE_BITS-1:0] phk, off;
    logic [PHASE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [PHASE_BITS-1:0] r_old;
    logic [SW-1:0] r_sum, n_sum;
    logic [SW-1:0] r_q;
    logic [LW:0] r_rem, rem2, dsub;
    logic signed [33:0] r_rx, r_ry, r_rz;
    logic r_neg;
    logic [31:0] ang;
    logic signed [33:0] za;
    logic [PHASE_BITS-1:0] rphase;
    logic signed [mpa_pkg::SB-1:0] r_xr, r_xi;
    logic signed [15:0] live_re, live_im, use_re, use_im;
    logic signed [15:0] r_hi_re, r_hi_im, r_hm_re, r_hm_im;
    logic signed [mpa_pkg::SB+15:0] r_pa, r_pb, r_pc, r_pd;
    logic [31:0] atn;

    function automatic logic signed [15:0] rot_round(input logic signed [33:0] v);
        logic signed [34:0] t;
        t = ($signed({v[33], v}) + 35'sd16384) >>> 15;
        if (t > 35'sd32767) return 16'sd32767;
        else if (t < -35'sd32768) return -16'sd32768;
        else return t[15:0];
    endfunction

    function automatic logic signed [mpa_pkg::SB-1:0] out_round(
        input logic signed [PW-1:0] v);
        logic signed [PW:0] t;
        logic signed [PW:0] hi;
        hi = (PW + 1)'((1 << (mpa_pkg::SB - 1)) - 1);
        t = ($signed({v[PW-1], v}) + (PW + 1)'(16384)) >>> 15;
        if (t > hi) return hi[mpa_pkg::SB-1:0];
        else if (t < -hi - 1) return (~hi[mpa_pkg::SB-1:0]);
        else return t[mpa_pkg::SB-1:0];
    endfunction

    mpa_vec #(.PHASE_BITS(PHASE_BITS)) u_vec (
        .i_clk  (i_clk),
        .i_load (i_ctrl.load),
        .i_step (i_ctrl.vec_step),
        .i_idx  (i_idx),
        .i_x    (i_re),
        .i_y    (i_im),
        .o_phase(phk)
    );

    assign off = i_ph0 - phk;
    assign n_sum = r_sum - (i_ctrl.full ? SW'(r_old) : '0) + SW'(off);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mem_rd) begin
            r_old <= r_mem[i_pos];
        end
        if (i_ctrl.upd) begin
            r_mem[i_pos] <= off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.sum_clr) begin
            r_sum <= '0;
        end else if (i_ctrl.upd) begin
            r_sum <= n_sum;
        end
    end

    // Restoring division of the window sum by the fill count, a bit a cycle.
    assign rem2 = {r_rem[LW-1:0], r_q[SW-1]};
    assign dsub = rem2 - {1'b0, i_nfill};
    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd) begin
            r_q <= n_sum;
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            if (rem2 >= {1'b0, i_nfill}) begin
                r_rem <= dsub;
                r_q <= {r_q[SW-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q <= {r_q[SW-2:0], 1'b0};
            end
        end
    end

    assign rphase = i_ctrl.method ? r_q[PHASE_BITS-1:0] : off;
    assign ang = {rphase, {(32 - PHASE_BITS){1'b0}}};
    assign za = {{2{ang[31]}}, ang};
    assign atn = mpa_pkg::atan_turn(i_idx);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rot_load) begin
            r_rx <= GAIN;
            r_ry <= '0;
            if (za > QTR) begin
                r_rz <= za - HALF;
                r_neg <= 1'b1;
            end else if (za < -QTR) begin
                r_rz <= za + HALF;
                r_neg <= 1'b1;
            end else begin
                r_rz <= za;
                r_neg <= 1'b0;
            end
        end else if (i_ctrl.rot_step) begin
            if (!r_rz[33]) begin
                r_rx <= r_rx - (r_ry >>> i_idx);
                r_ry <= r_ry + (r_rx >>> i_idx);
                r_rz <= r_rz - $signed({2'b00, atn});
            end else begin
                r_rx <= r_rx + (r_ry >>> i_idx);
                r_ry <= r_ry - (r_rx >>> i_idx);
                r_rz <= r_rz + $signed({2'b00, atn});
            end
        end
    end

    assign live_re = rot_round(r_neg ? -r_rx : r_rx);
    assign live_im = rot_round(r_neg ? -r_ry : r_ry);

    always_comb begin
        if (i_ctrl.live) begin
            use_re = live_re;
            use_im = live_im;
        end else if (i_ctrl.method) begin
            use_re = r_hm_re;
            use_im = r_hm_im;
        end else begin
            use_re = r_hi_re;
            use_im = r_hi_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_re <= mpa_pkg::ROT_ONE;
            r_hi_im <= '0;
            r_hm_re <= mpa_pkg::ROT_ONE;
            r_hm_im <= '0;
        end else if (i_ctrl.mul) begin
            if (i_ctrl.hold_inst) begin
                r_hi_re <= live_re;
                r_hi_im <= live_im;
            end
            if (i_ctrl.hold_mean) begin
                r_hm_re <= live_re;
                r_hm_im <= live_im;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_xr <= i_re;
            r_xi <= i_im;
        end
        if (i_ctrl.mul) begin
            r_pa <= r_xr * use_re;
            r_pb <= r_xi * use_im;
            r_pc <= r_xr * use_im;
            r_pd <= r_xi * use_re;
        end
    end

    assign o_re = out_round(PW'(r_pa) - PW'(r_pb));
    assign o_im = out_round(PW'(r_pc) + PW'(r_pd));
endmodule
`default_nettype wire
